// ===== src/cooperative_task_slot_scheduler_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cooperative task slot scheduler.
// Both macros check a clocked implication and are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef COOPERATIVE_TASK_SLOT_SCHEDULER_ASSERT_SVH
`define COOPERATIVE_TASK_SLOT_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ctss_pkg.sv =====
// ---------------------------------------------------------------------------
// ctss_pkg
// Shared request, result and control types of the task slot scheduler.
// ---------------------------------------------------------------------------
package ctss_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_SLEEP   = 2'd2,
    ACT_SWEEP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_CREATED   = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_DESTROYED = 3'd2,
    KIND_MISSING   = 3'd3,
    KIND_SLEEPING  = 3'd4,
    KIND_NO_TASK   = 3'd5,
    KIND_RUN       = 3'd6,
    KIND_IDLE      = 3'd7
  } kind_e;

  typedef struct packed {
    action_e            action;
    logic [4:0]         task_id;
    logic signed [31:0] delay_ms;
    logic [31:0]        now_ms;
  } req_t;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] task_id_res;
    logic       last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic create;
    logic sweep;
    logic flush;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;
    logic slot_free;
  } sts_t;

endpackage

// ===== src/ctss_ctrl.sv =====
// ---------------------------------------------------------------------------
// ctss_ctrl
// Sequencer of the task slot scheduler: decodes a request and steps scans.
// ---------------------------------------------------------------------------
module ctss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ctss_pkg::action_e action_i,
  input  ctss_pkg::sts_t    sts_i,
  output ctss_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  import ctss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_CREATE = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (action_i)
            ACT_CREATE: state_d = S_CREATE;
            ACT_SWEEP:  state_d = S_SWEEP;
            default:    state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      S_CREATE: begin
        cmd_o.create = 1'b1;
        if (sts_i.slot_free || sts_i.at_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.at_end) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== src/ctss_dp.sv =====
// ---------------------------------------------------------------------------
// ctss_dp
// Slot table, deadline memory, scan counter and result registers.
// ---------------------------------------------------------------------------
module ctss_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ctss_pkg::cmd_t cmd_i,
  input  ctss_pkg::req_t req_i,
  output ctss_pkg::sts_t sts_o,
  output logic           res_valid_o,
  output ctss_pkg::res_t res_o
);
  import ctss_pkg::*;

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  req_t                 req_q;
  logic [IdxW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      rd_addr;
  logic [NUM_SLOTS-1:0] live_q, live_d;
  logic [NUM_SLOTS-1:0] sleep_q, sleep_d;
  logic [31:0]          deadline_mem [NUM_SLOTS];
  logic [31:0]          rdata_q;
  logic                 pend_v_q, pend_v_d;
  logic [4:0]           pend_id_q, pend_id_d;
  logic                 res_valid_q, res_valid_d;
  res_t                 res_q, res_d;

  logic            id_ok;
  logic [4:0]      id_m1;
  logic [IdxW-1:0] id_idx;
  logic            tgt_live;
  logic            at_end;
  logic [4:0]      cur_id;
  logic            cur_live, cur_sleep;
  logic [31:0]     diff;
  logic            wake, run;
  logic            mem_we;
  logic [31:0]     mem_wdata;

  assign id_ok    = (req_q.task_id != 5'd0) && (int'(req_q.task_id) <= NUM_SLOTS);
  assign id_m1    = req_q.task_id - 5'd1;
  assign id_idx   = IdxW'(id_m1);
  assign tgt_live = id_ok && live_q[id_idx];

  assign at_end    = (cnt_q == LastIdx);
  assign cur_id    = 5'(cnt_q) + 5'd1;
  assign cur_live  = live_q[cnt_q];
  assign cur_sleep = sleep_q[cnt_q];

  // The memory holds delay plus arming time, so a sleeper is due once the
  // wrapped difference to the current time is zero or negative.
  assign diff = rdata_q - req_q.now_ms;
  assign wake = cur_sleep && ((diff == 32'd0) || diff[31]);
  assign run  = cur_live && (!cur_sleep || wake);

  assign mem_we    = cmd_i.exec && (req_q.action == ACT_SLEEP) && tgt_live;
  assign mem_wdata = $unsigned(req_q.delay_ms) + req_q.now_ms;

  assign rd_addr = (cmd_i.load || at_end) ? '0 : cnt_q + 1'b1;

  assign sts_o.at_end    = at_end;
  assign sts_o.slot_free = !cur_live;

  always_comb begin
    cnt_d       = cnt_q;
    live_d      = live_q;
    sleep_d     = sleep_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (cmd_i.load) begin
      cnt_d    = '0;
      pend_v_d = 1'b0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.exec) begin
      res_valid_d       = 1'b1;
      res_d.task_id_res = req_q.task_id;
      res_d.last        = 1'b1;
      if (req_q.action == ACT_SLEEP) begin
        if (tgt_live) begin
          sleep_d[id_idx] = 1'b1;
          res_d.kind      = KIND_SLEEPING;
        end else begin
          res_d.kind = KIND_NO_TASK;
        end
      end else begin
        if (tgt_live) begin
          live_d[id_idx]  = 1'b0;
          sleep_d[id_idx] = 1'b0;
          res_d.kind      = KIND_DESTROYED;
        end else begin
          res_d.kind = KIND_MISSING;
        end
      end
    end

    if (cmd_i.create) begin
      if (!cur_live) begin
        live_d[cnt_q]     = 1'b1;
        sleep_d[cnt_q]    = 1'b0;
        res_valid_d       = 1'b1;
        res_d.kind        = KIND_CREATED;
        res_d.task_id_res = cur_id;
        res_d.last        = 1'b1;
      end else if (at_end) begin
        res_valid_d       = 1'b1;
        res_d.kind        = KIND_FULL;
        res_d.task_id_res = 5'd0;
        res_d.last        = 1'b1;
      end
    end

    // A run result is held back one slot so that the final one can be
    // marked as last.
    if (cmd_i.sweep) begin
      if (wake) begin
        sleep_d[cnt_q] = 1'b0;
      end
      if (run) begin
        if (pend_v_q) begin
          res_valid_d       = 1'b1;
          res_d.kind        = KIND_RUN;
          res_d.task_id_res = pend_id_q;
          res_d.last        = 1'b0;
        end
        pend_v_d  = 1'b1;
        pend_id_d = cur_id;
      end
    end

    if (cmd_i.flush) begin
      res_valid_d = 1'b1;
      res_d.last  = 1'b1;
      if (pend_v_q) begin
        res_d.kind        = KIND_RUN;
        res_d.task_id_res = pend_id_q;
      end else begin
        res_d.kind        = KIND_IDLE;
        res_d.task_id_res = 5'd0;
      end
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      sleep_q     <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      live_q      <= live_d;
      sleep_q     <= sleep_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    cnt_q     <= cnt_d;
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      deadline_mem[id_idx] <= mem_wdata;
    end
    rdata_q <= deadline_mem[rd_addr];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/cooperative_task_slot_scheduler.sv =====
// ---------------------------------------------------------------------------
// cooperative_task_slot_scheduler
// Destroy and sleep: one exec state, whose result is registered as the block returns to idle.
// Create: scans slots one per cycle until it finds a free slot or reaches the last one.
// Sweep: one slot per cycle, then a flush state that emits the last result.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset clears all slots to free at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module cooperative_task_slot_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ctss_pkg::req_t req_i,
  output logic           res_valid_o,
  output ctss_pkg::res_t res_o
);
  import ctss_pkg::*;

  // A request is taken at a clock edge where start_i is high and busy_o is
  // low. The controller walks a single request through its states while
  // the datapath holds the slot table. Each slot's state lives in two
  // flip-flop vectors (live and sleeping) that reset clears directly.
  //
  // Sleepers are kept as a single wake deadline (delay plus the time the
  // sleep was armed) in a one-write, one-read memory. Charging elapsed time
  // on every sweep is then the same as comparing that deadline against the
  // current time: the wrapped difference being zero or negative means due.
  //
  // The sweep rate is set by the memory read port: one deadline is fetched
  // per cycle, ahead of the slot being evaluated. The create search walks
  // the slot table at the same pace, one slot per cycle.
  //
  // Run results are delayed by one found slot so the final one of a sweep
  // carries the last flag; the closing cycle emits either that held result
  // or an idle result when nothing ran.

  cmd_t cmd;
  sts_t sts;

  ctss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (req_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  ctss_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== src/ctss_checker.sv =====
// ---------------------------------------------------------------------------
// ctss_checker
// Port-level checks of the task slot scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "cooperative_task_slot_scheduler_assert.svh"

module ctss_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input ctss_pkg::res_t res_o
);
  import ctss_pkg::*;

  logic non_run_res;
  logic no_id_res;
  logic req_accept;

  assign non_run_res = res_valid_o && (res_o.kind != KIND_RUN);
  assign no_id_res   = res_valid_o && ((res_o.kind == KIND_FULL) || (res_o.kind == KIND_IDLE));
  assign req_accept  = start_i && !busy_o;

  // Only run results may be followed by more results of the same request.
  `CTSS_ASSERT_IMP(a_single_last, clk_i, rst_ni, non_run_res, res_o.last, "non-run result not last")
  // Full and idle results name no task.
  `CTSS_ASSERT_IMP(a_no_id, clk_i, rst_ni, no_id_res, res_o.task_id_res == 5'd0, "stray task id")
  // The block is busy in the cycle after a request is accepted.
  `CTSS_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, req_accept, busy_o, "not busy after accept")
  // Every result follows a cycle of work.
  `CTSS_ASSERT_IMP(a_res_after_busy, clk_i, rst_ni, res_valid_o, $past(busy_o), "result without work")

endmodule

bind cooperative_task_slot_scheduler ctss_checker u_ctss_checker (.*);
